/* rtl/box_mean_filter_2d_unit_macros.svh */
// Assertion macros shared by the box mean filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BOX_MEAN_FILTER_2D_UNIT_MACROS_SVH
`define BOX_MEAN_FILTER_2D_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define BMF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("box mean filter check failed");
// Expression must never be true outside reset.
`define BMF_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("box mean filter forbidden condition");
`else
`define BMF_ASSERT(lbl, clk, rstn, prop)
`define BMF_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/bmf_pkg.sv */
// Shared constants and types of the box mean filter.
// No dependencies; imported by every module of the block but bmf_queue.
package bmf_pkg;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_KERNEL = 7;
    localparam int MAX_HEIGHT     = 1024;
    localparam int CFG_W          = 11;
    localparam int KCFG_W         = 3;
    localparam int PIX_W          = 8;
    localparam int COORD_W        = 10;
    localparam int GEO_W          = 13;
    localparam int KER_W          = 4;
    localparam int KK_W           = 8;
    localparam int RAD_W          = 3;
    localparam int IDX_W          = 2;
    localparam int Q_DEPTH        = 4;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_KERNEL = 2'd2
    } t_reg_idx;

    // Effective image geometry handed from the front to the back.
    typedef struct packed {
        logic [GEO_W-1:0] width;
        logic [GEO_W-1:0] height;
        logic [RAD_W-1:0] rad;
        logic [KK_W-1:0]  kk;
    } t_geom;
endpackage

/* rtl/bmf_queue.sv */
// Small synchronous queue between the front and the back of the filter.
// Depends on no package; data width and depth come from the instantiator.
module bmf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_pop_data,
    output logic              o_full,
    output logic              o_empty
);
    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;

    assign o_full     = (r_count == (PW+1)'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_data[r_rd_ptr];

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

/* rtl/bmf_front.sv */
// Front of the filter: configuration registers, pixel position tracking
// and classification of which outputs each pixel completes. Uses bmf_pkg.
module bmf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7,
    localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CW  = CIW + 1,
    localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bmf_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           i_valid,
    input  logic [bmf_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_stall,
    input  logic                           i_q_full,
    output logic                           o_push,
    output logic [bmf_pkg::PIX_W-1:0]      o_pixel,
    output logic [bmf_pkg::COORD_W-1:0]    o_row,
    output logic [CIW-1:0]                 o_col,
    output logic [SW-1:0]                  o_slot,
    output logic [bmf_pkg::COORD_W-1:0]    o_i0,
    output logic [bmf_pkg::COORD_W-1:0]    o_i1,
    output logic [CIW-1:0]                 o_j0,
    output logic [CIW-1:0]                 o_j1,
    output logic                           o_has,
    output bmf_pkg::t_geom                 o_geom
);
    import bmf_pkg::*;

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic [KCFG_W-1:0]  r_kernel;
    logic [COORD_W-1:0] r_row;
    logic [CIW-1:0]     r_col;
    logic [SW-1:0]      r_slot;

    logic [GEO_W-1:0]   w_wid13;
    logic [CW-1:0]      w_w;
    logic [CFG_W-1:0]   w_h;
    logic [KER_W-1:0]   w_k;
    logic [RAD_W-1:0]   w_rad;
    logic               w_row_last;
    logic               w_col_last;
    logic               w_accept;
    logic               w_cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;
    assign w_accept    = i_valid && !i_q_full;
    assign o_push      = w_accept;
    assign w_cfg_hit   = i_cfg_valid && (i_cfg_index == REG_WIDTH ||
                         i_cfg_index == REG_HEIGHT || i_cfg_index == REG_KERNEL);

    // Effective sizes: zero acts as one, oversize is clipped.
    always_comb begin
        w_wid13 = GEO_W'(r_width);
        if (w_wid13 == '0) begin
            w_wid13 = GEO_W'(1);
        end else if (w_wid13 > GEO_W'(MAX_WIDTH)) begin
            w_wid13 = GEO_W'(MAX_WIDTH);
        end
        w_w = CW'(w_wid13);
        w_h = r_height;
        if (w_h == '0) begin
            w_h = CFG_W'(1);
        end else if (w_h > CFG_W'(MAX_HEIGHT)) begin
            w_h = CFG_W'(MAX_HEIGHT);
        end
        w_k = KER_W'(r_kernel);
        if (w_k == '0) begin
            w_k = KER_W'(1);
        end else if (w_k > KER_W'(MAX_KERNEL)) begin
            w_k = KER_W'(MAX_KERNEL);
        end
        w_rad = RAD_W'((w_k - 1'b1) >> 1);
    end

    assign o_geom.width  = GEO_W'(w_w);
    assign o_geom.height = GEO_W'(w_h);
    assign o_geom.rad    = w_rad;
    assign o_geom.kk     = KK_W'(w_k) * KK_W'(w_k);

    assign w_row_last = ((CFG_W'(r_row) + 1'b1) == w_h);
    assign w_col_last = ((CW'(r_col) + 1'b1) == w_w);

    // Classify which output rows and columns this pixel completes.
    always_comb begin
        logic row_ok;
        logic col_ok;
        row_ok = w_row_last || (r_row >= COORD_W'(w_rad));
        col_ok = w_col_last || (r_col >= CIW'(w_rad));
        o_i1   = w_row_last ? r_row : r_row - COORD_W'(w_rad);
        o_i0   = (r_row >= COORD_W'(w_rad)) ? r_row - COORD_W'(w_rad) : '0;
        o_j1   = w_col_last ? r_col : r_col - CIW'(w_rad);
        o_j0   = (r_col >= CIW'(w_rad)) ? r_col - CIW'(w_rad) : '0;
        o_has  = row_ok && col_ok;
    end

    assign o_pixel = i_pixel;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_slot  = r_slot;

    // Configuration registers and raster position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1024);
            r_height <= CFG_W'(1024);
            r_kernel <= KCFG_W'(3);
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
        end else if (w_cfg_hit) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_KERNEL: r_kernel <= i_cfg_data[KCFG_W-1:0];
                default:    r_kernel <= r_kernel;
            endcase
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (w_accept) begin
            if (w_col_last) begin
                r_col <= '0;
                if (w_row_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_slot <= (r_slot == SW'(MAX_KERNEL - 1)) ? '0 : r_slot + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end
endmodule

/* rtl/bmf_back.sv */
// Back of the filter: line store, window summation one pixel per cycle,
// serial division and the result register. Uses bmf_pkg.
module bmf_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7,
    localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic [bmf_pkg::PIX_W-1:0]      i_pixel,
    input  logic [bmf_pkg::COORD_W-1:0]    i_row,
    input  logic [CIW-1:0]                 i_col,
    input  logic [SW-1:0]                  i_slot,
    input  logic [bmf_pkg::COORD_W-1:0]    i_i0,
    input  logic [bmf_pkg::COORD_W-1:0]    i_i1,
    input  logic [CIW-1:0]                 i_j0,
    input  logic [CIW-1:0]                 i_j1,
    input  logic                           i_has,
    input  bmf_pkg::t_geom                 i_geom,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bmf_pkg::PIX_W-1:0]      o_mean_value,
    output logic [bmf_pkg::COORD_W-1:0]    o_out_row,
    output logic [bmf_pkg::COORD_W-1:0]    o_out_col,
    output logic                           o_last_of_run
);
    import bmf_pkg::*;

    localparam int SUM_W = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_FETCH, S_SETUP, S_READ, S_DRAIN, S_DIV, S_OUT
    } t_state;

    t_state             r_state;
    logic [PIX_W-1:0]   r_mem [MAX_KERNEL][MAX_WIDTH];
    logic [PIX_W-1:0]   r_rd_data;
    logic               r_rd_v;
    logic [COORD_W-1:0] r_a;
    logic [SW-1:0]      r_aslot;
    logic [COORD_W-1:0] r_i1, r_i;
    logic [CIW-1:0]     r_j0, r_j1, r_j;
    logic [COORD_W-1:0] r_r, r_r1;
    logic [CIW-1:0]     r_c, r_c0, r_c1;
    logic [SW-1:0]      r_slot;
    logic [SUM_W-1:0]   r_acc;
    logic [SUM_W-1:0]   r_dvd;
    logic [KK_W-1:0]    r_rem;
    logic [CNT_W-1:0]   r_cnt;

    logic               w_wr_en;
    logic               w_rd_en;
    logic               w_last;
    logic [COORD_W-1:0] w_r0, w_r1;
    logic [CIW-1:0]     w_c0, w_c1;
    logic [SW-1:0]      w_slot0;
    logic [KK_W:0]      w_trial;
    logic [KK_W-1:0]    w_rem_n;
    logic [SUM_W-1:0]   w_dvd_n;

    assign o_pop   = (r_state == S_FETCH) && !i_empty;
    assign w_wr_en = o_pop;
    assign w_rd_en = (r_state == S_READ);
    assign w_last  = (r_i == r_i1) && (r_j == r_j1);

    // Line store: one write per popped pixel, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_slot][i_col] <= i_pixel;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_slot][r_c];
        end
    end

    // Window bounds, clipped to the image, and ring slot of its first row.
    always_comb begin
        logic [CFG_W-1:0]   rsum;
        logic [CIW:0]       csum;
        logic [SW:0]        d;
        logic [SW:0]        s;
        w_r0 = (r_i >= COORD_W'(i_geom.rad)) ? r_i - COORD_W'(i_geom.rad) : '0;
        rsum = CFG_W'(r_i) + CFG_W'(i_geom.rad);
        w_r1 = (rsum < CFG_W'(i_geom.height)) ? COORD_W'(rsum)
                                              : COORD_W'(i_geom.height - 1'b1);
        w_c0 = (r_j >= CIW'(i_geom.rad)) ? r_j - CIW'(i_geom.rad) : '0;
        csum = (CIW+1)'(r_j) + (CIW+1)'(i_geom.rad);
        w_c1 = (csum < (CIW+1)'(i_geom.width)) ? CIW'(csum)
                                               : CIW'(i_geom.width - 1'b1);
        d    = (SW+1)'(r_a - w_r0);
        s    = (SW+1)'(r_aslot) + (SW+1)'(MAX_KERNEL) - d;
        w_slot0 = (s >= (SW+1)'(MAX_KERNEL)) ? SW'(s - (SW+1)'(MAX_KERNEL)) : SW'(s);
    end

    // One restoring division step.
    always_comb begin
        w_trial = {r_rem, r_dvd[SUM_W-1]};
        if (w_trial >= (KK_W+1)'(i_geom.kk)) begin
            w_rem_n = KK_W'(w_trial - (KK_W+1)'(i_geom.kk));
            w_dvd_n = {r_dvd[SUM_W-2:0], 1'b1};
        end else begin
            w_rem_n = KK_W'(w_trial);
            w_dvd_n = {r_dvd[SUM_W-2:0], 1'b0};
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH;
            r_rd_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_FETCH: begin
                    if (!i_empty) begin
                        r_a     <= i_row;
                        r_aslot <= i_slot;
                        r_i1    <= i_i1;
                        r_j0    <= i_j0;
                        r_j1    <= i_j1;
                        r_i     <= i_i0;
                        r_j     <= i_j0;
                        if (i_has) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_r     <= w_r0;
                    r_r1    <= w_r1;
                    r_c     <= w_c0;
                    r_c0    <= w_c0;
                    r_c1    <= w_c1;
                    r_slot  <= w_slot0;
                    r_acc   <= '0;
                    r_rd_v  <= 1'b0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_rd_v) begin
                        r_acc <= r_acc + SUM_W'(r_rd_data);
                    end
                    r_rd_v <= 1'b1;
                    if (r_c == r_c1) begin
                        if (r_r == r_r1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_r    <= r_r + 1'b1;
                            r_c    <= r_c0;
                            r_slot <= (r_slot == SW'(MAX_KERNEL - 1)) ? '0 : r_slot + 1'b1;
                        end
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_dvd   <= r_acc + SUM_W'(r_rd_data);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(SUM_W);
                    r_rd_v  <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dvd <= w_dvd_n;
                    r_rem <= w_rem_n;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        o_mean_value  <= w_dvd_n[PIX_W-1:0];
                        o_out_row     <= r_i;
                        o_out_col     <= COORD_W'(r_j);
                        o_last_of_run <= w_last;
                        o_valid       <= 1'b1;
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (w_last) begin
                            r_state <= S_FETCH;
                        end else if (r_j != r_j1) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_SETUP;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_j     <= r_j0;
                            r_state <= S_SETUP;
                        end
                    end
                end
                default: r_state <= S_FETCH;
            endcase
        end
    end
endmodule

/* rtl/box_mean_filter_2d_unit.sv */
// Top level of the streaming zero-padded 2-D box mean filter.
// Depends on bmf_pkg, bmf_front, bmf_queue, bmf_back and the macro header.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------
//  config   | in        | i_cfg_valid/o_cfg_ready  | i_cfg_index, i_cfg_data
//  pixel    | in        | i_valid/o_stall          | i_pixel
//  result   | out       | o_valid/i_stall          | o_mean_value, o_out_row,
//           |           |                          | o_out_col, o_last_of_run
//
// Each result reads its window from the line store one pixel at a time and then
// passes through the serial divider; the line store's single read port and the
// divider set this pace. A pixel that completes no result is only stored in the back.
// Four classified pixels fit in the queue; input flows while results stall until full.
// Reset is synchronous and active low; the line store needs no clearing.
`include "box_mean_filter_2d_unit_macros.svh"
module box_mean_filter_2d_unit #(
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bmf_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bmf_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bmf_pkg::PIX_W-1:0]      o_mean_value,
    output logic [bmf_pkg::COORD_W-1:0]    o_out_row,
    output logic [bmf_pkg::COORD_W-1:0]    o_out_col,
    output logic                           o_last_of_run
);
    import bmf_pkg::*;

    localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int QW  = PIX_W + 3 * COORD_W + 3 * CIW + SW + 1;

    logic               w_q_full, w_q_empty, w_push, w_pop;
    logic [QW-1:0]      w_q_in, w_q_out;
    logic [PIX_W-1:0]   f_pixel, b_pixel;
    logic [COORD_W-1:0] f_row, f_i0, f_i1, b_row, b_i0, b_i1;
    logic [CIW-1:0]     f_col, f_j0, f_j1, b_col, b_j0, b_j1;
    logic [SW-1:0]      f_slot, b_slot;
    logic               f_has, b_has;
    t_geom              w_geom;

    bmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready),
        .i_valid(i_valid), .i_pixel(i_pixel), .o_stall(o_stall),
        .i_q_full(w_q_full), .o_push(w_push),
        .o_pixel(f_pixel), .o_row(f_row), .o_col(f_col), .o_slot(f_slot),
        .o_i0(f_i0), .o_i1(f_i1), .o_j0(f_j0), .o_j1(f_j1), .o_has(f_has),
        .o_geom(w_geom)
    );

    // Pack one classified pixel for the queue.
    assign w_q_in = {f_pixel, f_row, f_i0, f_i1, f_col, f_j0, f_j1, f_slot, f_has};
    assign {b_pixel, b_row, b_i0, b_i1, b_col, b_j0, b_j1, b_slot, b_has} = w_q_out;

    bmf_queue #(.DATA_W(QW), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_push_data(w_q_in),
        .i_pop(w_pop), .o_pop_data(w_q_out),
        .o_full(w_q_full), .o_empty(w_q_empty)
    );

    bmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_q_empty), .o_pop(w_pop),
        .i_pixel(b_pixel), .i_row(b_row), .i_col(b_col), .i_slot(b_slot),
        .i_i0(b_i0), .i_i1(b_i1), .i_j0(b_j0), .i_j1(b_j1), .i_has(b_has),
        .i_geom(w_geom),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_mean_value(o_mean_value), .o_out_row(o_out_row),
        .o_out_col(o_out_col), .o_last_of_run(o_last_of_run)
    );

    // The queue never takes a transfer while full and never gives one while empty.
    `BMF_NEVER(a_push_full, i_clk, i_rst_n, w_push && w_q_full)
    `BMF_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && w_q_empty)
    // After the last result of a pixel the back fetches before showing another.
    `BMF_ASSERT(a_gap_last, i_clk, i_rst_n, (o_valid && !i_stall && o_last_of_run) |=> !o_valid)
endmodule

/* sim/box_mean_filter_2d_checker.sv */
// Result checker for the box mean filter: tracks register writes and pixel transfers,
// predicts every filtered pixel and compares the result transfers in order.
// Depends on bmf_pkg for widths and register indexes.
module box_mean_filter_2d_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [bmf_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    input  logic                        i_stall,
    input  logic [bmf_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic [bmf_pkg::PIX_W-1:0]   i_mean_value,
    input  logic [bmf_pkg::COORD_W-1:0] i_out_row,
    input  logic [bmf_pkg::COORD_W-1:0] i_out_col,
    input  logic                        i_last_of_run,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bmf_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]   mean;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_filtered;

    t_filtered   due_q[$];
    logic [PIX_W-1:0] row_ring [DEF_MAX_KERNEL][DEF_MAX_WIDTH];
    int unsigned width_reg, height_reg, kernel_reg;
    int unsigned next_row, next_col;
    int          mismatches;

    // Sum of the clipped window around (i,j); padding adds nothing.
    function automatic int unsigned window_total(int unsigned i, int unsigned j,
            int unsigned rad, int unsigned w, int unsigned h);
        int unsigned total, r0, r1, c0, c1;
        total = 0;
        r0 = (i >= rad) ? i - rad : 0;
        r1 = (i + rad < h) ? i + rad : h - 1;
        c0 = (j >= rad) ? j - rad : 0;
        c1 = (j + rad < w) ? j + rad : w - 1;
        for (int unsigned r = r0; r <= r1; r++)
            for (int unsigned c = c0; c <= c1; c++)
                total += row_ring[r % DEF_MAX_KERNEL][c];
        return total;
    endfunction

    // Store one pixel and queue every filtered pixel that it completes.
    task automatic predict_means(input logic [PIX_W-1:0] px);
        int unsigned w, h, k, rad, a, b, i0, i1, j0, j1;
        bit          rows_done, cols_done;
        t_filtered   res;
        w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
        k = (kernel_reg == 0) ? 1 : (kernel_reg > DEF_MAX_KERNEL ? DEF_MAX_KERNEL : kernel_reg);
        rad = (k - 1) / 2;
        a = (next_row >= h) ? h - 1 : next_row;
        b = (next_col >= w) ? w - 1 : next_col;
        row_ring[a % DEF_MAX_KERNEL][b] = px;

        rows_done = 1;
        if (a + 1 == h) begin
            i0 = (a >= rad) ? a - rad : 0;
            i1 = a;
        end else if (a >= rad) begin
            i0 = a - rad;
            i1 = i0;
        end else begin
            rows_done = 0;
        end
        cols_done = 1;
        if (b + 1 == w) begin
            j0 = (b >= rad) ? b - rad : 0;
            j1 = b;
        end else if (b >= rad) begin
            j0 = b - rad;
            j1 = j0;
        end else begin
            cols_done = 0;
        end

        if (rows_done && cols_done) begin
            for (int unsigned i = i0; i <= i1; i++) begin
                for (int unsigned j = j0; j <= j1; j++) begin
                    res.mean = PIX_W'(window_total(i, j, rad, w, h) / (k * k));
                    res.row  = COORD_W'(i);
                    res.col  = COORD_W'(j);
                    res.last = (i == i1 && j == j1);
                    due_q.push_back(res);
                end
            end
        end

        // Raster advance with wrap at the end of the image.
        if (b + 1 >= w) begin
            next_col = 0;
            next_row = (a + 1 >= h) ? 0 : a + 1;
        end else begin
            next_col = b + 1;
            next_row = a;
        end
    endtask

    // Compare one result transfer with the oldest prediction.
    task automatic check_result();
        t_filtered exp_r;
        if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: mean %0d row %0d col %0d last %0d",
                         i_mean_value, i_out_row, i_out_col, i_last_of_run);
        end else begin
            exp_r = due_q.pop_front();
            if (exp_r.mean !== i_mean_value || exp_r.row !== i_out_row ||
                exp_r.col !== i_out_col || exp_r.last !== i_last_of_run) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected mean %0d row %0d col %0d last %0d,",
                              " got mean %0d row %0d col %0d last %0d"},
                             exp_r.mean, exp_r.row, exp_r.col, exp_r.last,
                             i_mean_value, i_out_row, i_out_col, i_last_of_run);
            end
        end
    endtask

    // Follow every transfer at the clock edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = DEF_MAX_WIDTH;
            height_reg = MAX_HEIGHT;
            kernel_reg = 3;
            next_row   = 0;
            next_col   = 0;
            mismatches = 0;
            due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH: begin
                        width_reg = i_cfg_data;
                        next_row = 0;
                        next_col = 0;
                    end
                    REG_HEIGHT: begin
                        height_reg = i_cfg_data;
                        next_row = 0;
                        next_col = 0;
                    end
                    REG_KERNEL: begin
                        kernel_reg = i_cfg_data[KCFG_W-1:0];
                        next_row = 0;
                        next_col = 0;
                    end
                    default: ;
                endcase
            end
            if (i_valid && !i_stall)
                predict_means(i_pixel);
            if (i_res_valid && !i_res_stall)
                check_result();
        end
        o_fail_count <= mismatches;
        o_pending    <= due_q.size();
    end
endmodule

/* sim/box_mean_filter_2d_unit_tb.sv */
// Testbench top for the box mean filter: clock, reset, register writes, pixel stimulus
// with bursts and result-side stalls, and the final verdict.
// Depends on bmf_pkg, box_mean_filter_2d_unit and box_mean_filter_2d_checker.
module box_mean_filter_2d_unit_tb;
    import bmf_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [PIX_W-1:0]   i_pixel;
    logic               o_valid;
    logic               i_stall;
    logic [PIX_W-1:0]   o_mean_value;
    logic [COORD_W-1:0] o_out_row;
    logic [COORD_W-1:0] o_out_col;
    logic               o_last_of_run;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 random_pixels = 0;
    bit                 hold_request = 0;

    box_mean_filter_2d_unit dut (.*);

    box_mean_filter_2d_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid, .i_stall(o_stall), .i_pixel,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_mean_value(o_mean_value),
        .i_out_row(o_out_row), .i_out_col(o_out_col), .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stall pattern: random stalls at a rate redrawn from 0, 25, 50 or 75 percent,
    // and one long hold-off is made on request while pixels keep coming.
    int stall_pct = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        if (cycle_count % 256 == 0)
            stall_pct = $urandom_range(0, 3) * 25;
        if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // One pixel transfer; the sender works in bursts separated by gaps.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Wait until every predicted result has arrived and the back end is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write transfer; the caller drops valid after its last write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_geometry(input int w, input int h, input int k);
        drain();
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_KERNEL, CFG_W'(k));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int w, h, k, count;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_pixel     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: the first row of a full-size image completes nothing.
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_random(2);

        // Zero sizes and zero kernel behave as a one-pixel image.
        set_geometry(0, 0, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'h55);

        // Largest kernel on a 4x4 image: the last corner completes sixteen results.
        set_geometry(4, 4, 7);
        for (int n = 0; n < 16; n++)
            send_pixel(8'd255);

        // Oversize width on a single row with an even kernel.
        set_geometry(2047, 1, 2);
        send_pixel(8'hAA);
        send_random(3);

        // Oversize height on a single column with kernel 5.
        set_geometry(1, 2047, 5);
        send_random(6);

        // A write to the spare index changes nothing.
        drain();
        write_reg(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
        i_cfg_valid <= 1'b0;
        send_random(2);

        // Long hold-off at the receiver while a 5x5 image streams in.
        set_geometry(5, 5, 3);
        hold_request = 1;
        send_random(25);

        // Start of a row at maximum width with kernel 6.
        set_geometry(1024, 1, 6);
        send_random(20);

        // Random geometries, mostly small whole images, some broken off early or run past the end.
        while (random_pixels < 30) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
            k = $urandom_range(0, 7);
            count = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, 2 * count);
            if (count > 36)
                count = 36;
            set_geometry(w, h, k);
            send_random(count);
            random_pixels += count;
        end

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
